>>> hw/rtl/svcr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sign vote package
// Shared constants, register indexes and types of the sign vote block.
// ----------------------------------------------------------------------------
package svcr_pkg;

    localparam int unsigned NUM_CLASSES_DEF = 4;
    localparam int unsigned COUNT_WIDTH_DEF = 8;

    localparam int unsigned CODE_W    = 3;
    localparam int unsigned REACT_W   = 2;
    localparam int unsigned CFG_W     = 8;
    localparam int unsigned CFG_IDX_W = 2;

    localparam logic [CFG_W-1:0] COUNT_LIMIT_RST = 8'd30;
    localparam logic [CFG_W-1:0] CONFIRM_THR_RST = 8'd20;
    localparam logic [CFG_W-1:0] RELEASE_LVL_RST = 8'd5;

    localparam int unsigned Q_DEPTH = 2;
    localparam int unsigned Q_PTR_W = 1;
    localparam int unsigned Q_CNT_W = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_COUNT_LIMIT = 2'd0,
        CFG_CONFIRM_THR = 2'd1,
        CFG_RELEASE_LVL = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic [CFG_W-1:0] count_limit;
        logic [CFG_W-1:0] confirm_threshold;
        logic [CFG_W-1:0] release_level;
    } t_cfg;

endpackage

>>> hw/rtl/svcr_cfg_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sign vote configuration registers
// Holds limit, confirm threshold and release level; unknown indexes are dropped.
// ----------------------------------------------------------------------------
module svcr_cfg_regs (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [svcr_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [svcr_pkg::CFG_W-1:0]     i_cfg_data,
    output svcr_pkg::t_cfg                 o_cfg
);
    import svcr_pkg::*;

    t_cfg r_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.count_limit       <= COUNT_LIMIT_RST;
            r_cfg.confirm_threshold <= CONFIRM_THR_RST;
            r_cfg.release_level     <= RELEASE_LVL_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_COUNT_LIMIT: r_cfg.count_limit       <= i_cfg_data;
                CFG_CONFIRM_THR: r_cfg.confirm_threshold <= i_cfg_data;
                CFG_RELEASE_LVL: r_cfg.release_level     <= i_cfg_data;
                default: ;
            endcase
        end
    end

endmodule

>>> hw/rtl/svcr_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sign vote front end
// Updates the vote counters and confirmed flags, and forms the release mask.
// ----------------------------------------------------------------------------
module svcr_front #(
    parameter int unsigned NUM_CLASSES = svcr_pkg::NUM_CLASSES_DEF,
    parameter int unsigned COUNT_WIDTH = svcr_pkg::COUNT_WIDTH_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  svcr_pkg::t_cfg              i_cfg,
    input  logic                        i_accept,
    input  logic [svcr_pkg::CODE_W-1:0] i_class_code,
    output logic                        o_mask_valid,
    output logic [NUM_CLASSES-1:0]      o_mask
);
    import svcr_pkg::*;

    localparam int unsigned CMP_W = ((COUNT_WIDTH > CFG_W) ? COUNT_WIDTH : CFG_W) + 1;
    localparam logic [CMP_W-1:0] COUNT_MAX = CMP_W'((1 << COUNT_WIDTH) - 1);

    logic [COUNT_WIDTH-1:0] r_count [NUM_CLASSES];
    logic [COUNT_WIDTH-1:0] n_count [NUM_CLASSES];
    logic [NUM_CLASSES-1:0] r_flag;
    logic [NUM_CLASSES-1:0] n_flag;

    logic [CMP_W-1:0]       limit;
    logic [CMP_W-1:0]       cur;
    logic [CMP_W-1:0]       inc;
    logic [COUNT_WIDTH-1:0] best;
    logic [NUM_CLASSES-1:0] is_lead;
    logic [NUM_CLASSES-1:0] flag_set;
    logic [NUM_CLASSES-1:0] mask;

    always_comb begin
        limit = (CMP_W'(i_cfg.count_limit) > COUNT_MAX) ? COUNT_MAX
                                                         : CMP_W'(i_cfg.count_limit);
        cur = '0;
        inc = '0;
        // rise the named class, capped at the limit; fall the rest, floored at zero
        for (int i = 0; i < NUM_CLASSES; i++) begin
            cur = CMP_W'(r_count[i]);
            inc = cur + CMP_W'(1);
            if (CMP_W'(i_class_code) == CMP_W'(i)) begin
                n_count[i] = (inc < limit) ? inc[COUNT_WIDTH-1:0] : limit[COUNT_WIDTH-1:0];
            end else begin
                n_count[i] = (r_count[i] != '0) ? r_count[i] - COUNT_WIDTH'(1) : '0;
            end
        end

        // leader: beats every lower index strictly, no higher index beats it
        for (int i = 0; i < NUM_CLASSES; i++) begin
            is_lead[i] = 1'b1;
            for (int j = 0; j < NUM_CLASSES; j++) begin
                if (j < i && !(n_count[i] > n_count[j])) begin
                    is_lead[i] = 1'b0;
                end
                if (j > i && n_count[j] > n_count[i]) begin
                    is_lead[i] = 1'b0;
                end
            end
        end

        best = '0;
        for (int i = 0; i < NUM_CLASSES; i++) begin
            if (is_lead[i]) begin
                best = best | n_count[i];
            end
        end

        flag_set = r_flag;
        if (CMP_W'(best) >= CMP_W'(i_cfg.confirm_threshold)) begin
            flag_set = r_flag | is_lead;
        end

        for (int i = 0; i < NUM_CLASSES; i++) begin
            mask[i] = flag_set[i]
                && (CMP_W'(n_count[i]) <= CMP_W'(i_cfg.release_level));
        end
        n_flag = flag_set & ~mask;
    end

    assign o_mask       = mask;
    assign o_mask_valid = (mask != '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flag <= '0;
            for (int i = 0; i < NUM_CLASSES; i++) begin
                r_count[i] <= '0;
            end
        end else if (i_accept) begin
            r_flag <= n_flag;
            for (int i = 0; i < NUM_CLASSES; i++) begin
                r_count[i] <= n_count[i];
            end
        end
    end

endmodule

>>> hw/rtl/svcr_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sign vote release queue
// Short register queue of release masks between front and back end.
// ----------------------------------------------------------------------------
module svcr_queue #(
    parameter int unsigned WIDTH = svcr_pkg::NUM_CLASSES_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_empty,
    output logic [WIDTH-1:0] o_data
);
    import svcr_pkg::*;

    logic [WIDTH-1:0]   r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wr_ptr;
    logic [Q_PTR_W-1:0] r_rd_ptr;
    logic [Q_CNT_W-1:0] r_count;
    logic               do_push;
    logic               do_pop;

    assign o_full  = (r_count == Q_CNT_W'(Q_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + Q_PTR_W'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + Q_PTR_W'(1);
            end
            unique case ({do_push, do_pop})
                2'b10:   r_count <= r_count + Q_CNT_W'(1);
                2'b01:   r_count <= r_count - Q_CNT_W'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

>>> hw/rtl/svcr_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sign vote back end
// Walks a release mask lowest class first, one reaction per request.
// ----------------------------------------------------------------------------
module svcr_back #(
    parameter int unsigned NUM_CLASSES = svcr_pkg::NUM_CLASSES_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_q_empty,
    input  logic [NUM_CLASSES-1:0]       i_q_data,
    output logic                         o_q_pop,
    input  logic                         i_pop,
    output logic                         o_empty,
    output logic [svcr_pkg::REACT_W-1:0] o_react_class,
    output logic                         o_last_of_run
);
    import svcr_pkg::*;

    logic [NUM_CLASSES-1:0] r_mask;
    logic [NUM_CLASSES-1:0] n_mask;
    logic [NUM_CLASSES-1:0] low;
    logic [NUM_CLASSES-1:0] rest;
    logic [REACT_W-1:0]     react;
    logic                   take;
    logic                   load;
    logic                   q_pop;

    always_comb begin
        low  = r_mask & (~r_mask + NUM_CLASSES'(1));
        rest = r_mask & ~low;
        react = '0;
        for (int i = 0; i < NUM_CLASSES; i++) begin
            if (low[i]) begin
                react = react | REACT_W'(i);
            end
        end
        take  = i_pop && (r_mask != '0);
        load  = (r_mask == '0) || (take && (rest == '0));
        q_pop = load && !i_q_empty;
        n_mask = take ? rest : r_mask;
        if (q_pop) begin
            n_mask = i_q_data;
        end
    end

    assign o_q_pop       = q_pop;
    assign o_empty       = (r_mask == '0);
    assign o_react_class = react;
    assign o_last_of_run = (rest == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask <= '0;
        end else begin
            r_mask <= n_mask;
        end
    end

endmodule

>>> hw/rtl/sign_vote_confirm_release.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sign vote, confirm and release
// Votes detected sign classes, confirms a steady leader and reports each
// confirmed class once its votes have faded.
// ----------------------------------------------------------------------------
// A detection is taken whenever full is low: the front end
// updates every class counter, confirms the leader and forms the set of
// classes to release, all in the cycle of the push. Items releasing nothing
// leave no trace downstream. Release sets go through a two-entry queue to the
// back end, which shows one reaction at a time on the result ports, lowest
// class first, with last_of_run marking the final one of a set. The input
// side therefore runs at one item per cycle while full is low, and an item
// that releases k classes gives k reactions on the result side; full rises
// only when the queue and the back end's current set are all waiting on pop.
// Configuration writes are always ready and take effect on the next item.
// ----------------------------------------------------------------------------
module sign_vote_confirm_release #(
    parameter int unsigned NUM_CLASSES = svcr_pkg::NUM_CLASSES_DEF,
    parameter int unsigned COUNT_WIDTH = svcr_pkg::COUNT_WIDTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // detection channel
    input  logic                           push,
    output logic                           full,
    input  logic [svcr_pkg::CODE_W-1:0]    i_class_code,
    // reaction channel
    output logic                           empty,
    input  logic                           pop,
    output logic [svcr_pkg::REACT_W-1:0]   o_react_class,
    output logic                           o_last_of_run,
    // configuration write channel
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [svcr_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [svcr_pkg::CFG_W-1:0]     i_cfg_data
);
    import svcr_pkg::*;

    t_cfg                   cfg;
    logic                   accept;
    logic                   mask_valid;
    logic [NUM_CLASSES-1:0] mask;
    logic                   q_full;
    logic [NUM_CLASSES-1:0] q_data;
    logic                   q_empty;
    logic                   q_pop;

    // take a detection only while the queue has room for its release set
    assign full   = q_full;
    assign accept = push && !q_full;

    svcr_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    // front end: vote, confirm and pick the classes to release
    svcr_front #(
        .NUM_CLASSES (NUM_CLASSES),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (cfg),
        .i_accept     (accept),
        .i_class_code (i_class_code),
        .o_mask_valid (mask_valid),
        .o_mask       (mask)
    );

    // queue only sets that hold at least one release
    svcr_queue #(
        .WIDTH (NUM_CLASSES)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (accept && mask_valid),
        .i_data  (mask),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_data  (q_data)
    );

    // back end: serialise each set onto the reaction channel
    svcr_back #(
        .NUM_CLASSES (NUM_CLASSES)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_empty     (q_empty),
        .i_q_data      (q_data),
        .o_q_pop       (q_pop),
        .i_pop         (pop),
        .o_empty       (empty),
        .o_react_class (o_react_class),
        .o_last_of_run (o_last_of_run)
    );

endmodule

>>> tb/sv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sign vote testbench
// Feeds detection requests through the vote block under changing register
// settings and idle patterns, predicts every reaction the votes should cause
// and checks each one in order as it is popped.
// ----------------------------------------------------------------------------
module tb;
    import svcr_pkg::*;

    localparam int unsigned NCLS             = NUM_CLASSES_DEF;
    localparam int unsigned CW               = COUNT_WIDTH_DEF;
    localparam int unsigned COUNT_TOP        = (1 << CW) - 1;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE = 2'd3;
    localparam logic [CODE_W-1:0] CODE_STOP  = 3'd0;
    localparam logic [CODE_W-1:0] CODE_S30   = 3'd1;
    localparam logic [CODE_W-1:0] CODE_S50   = 3'd2;
    localparam logic [CODE_W-1:0] CODE_BUMP  = 3'd3;
    localparam logic [CODE_W-1:0] CODE_NONE  = 3'd4;
    localparam int unsigned RESET_CYCLES     = 8;
    localparam int unsigned SETTLE_CYCLES    = 6;
    localparam int unsigned LONG_HOLD_CYCLES = 120;
    localparam int unsigned WATCHDOG_LIMIT   = 2000;
    localparam int unsigned ITEMS_PER_PHASE  = 30;
    localparam int unsigned PRESSURE_ITEMS   = 20;

    typedef struct packed {
        logic [REACT_W-1:0] cls;
        logic               last;
    } t_reaction;

    // ------------------------------------------------------------------------
    // Block ports, inputs at known values from time zero
    // ------------------------------------------------------------------------
    logic                 i_clk        = 1'b0;
    logic                 i_rst_n      = 1'b0;
    logic                 push         = 1'b0;
    logic                 full;
    logic [CODE_W-1:0]    i_class_code = '0;
    logic                 empty;
    logic                 pop          = 1'b0;
    logic [REACT_W-1:0]   o_react_class;
    logic                 o_last_of_run;
    logic                 i_cfg_valid  = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index  = '0;
    logic [CFG_W-1:0]     i_cfg_data   = '0;

    // ------------------------------------------------------------------------
    // Testbench state
    // ------------------------------------------------------------------------
    logic [CODE_W-1:0] detections[$];        // detections waiting to be offered
    t_reaction         pending_reactions[$]; // reactions owed by the block, oldest first
    int unsigned       mismatches   = 0;
    int unsigned       tx_idle_pct  = 37;
    int unsigned       rx_idle_pct  = 81;
    logic              hold_req     = 1'b0;  // ask the receiver for one long hold-off
    logic              hold_taken   = 1'b0;
    int unsigned       hold_left    = 0;
    int unsigned       quiet_cycles = 0;

    // Own copy of the vote state and the registers
    logic [CW-1:0]     votes[NCLS];
    logic              confirmed[NCLS];
    logic [CFG_W-1:0]  limit_q;
    logic [CFG_W-1:0]  thresh_q;
    logic [CFG_W-1:0]  release_q;

    sign_vote_confirm_release dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .push          (push),
        .full          (full),
        .i_class_code  (i_class_code),
        .empty         (empty),
        .pop           (pop),
        .o_react_class (o_react_class),
        .o_last_of_run (o_last_of_run),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // Vote predictor: update every counter for one detection, confirm the
    // leader and queue the classes that have faded to the release level
    // ------------------------------------------------------------------------
    function automatic void tally_detection(input logic [CODE_W-1:0] code);
        int unsigned cnt;
        int unsigned best;
        int unsigned lead;
        int unsigned ceiling;
        int unsigned fired;
        t_reaction   r;
        best  = 0;
        lead  = 0;
        fired = 0;
        // clip a limit wider than a counter to the counter's top value
        ceiling = (limit_q > COUNT_TOP) ? COUNT_TOP : limit_q;
        // named class rises up to the ceiling, all others fall by one, floored at zero;
        // codes beyond the last class name nothing, so every counter falls
        for (int i = 0; i < NCLS; i++) begin
            cnt = votes[i];
            if (i == code) begin
                cnt = (cnt + 1 < ceiling) ? cnt + 1 : ceiling;
            end else begin
                cnt = (cnt > 0) ? cnt - 1 : 0;
            end
            votes[i] = cnt[CW-1:0];
        end
        // strict compare keeps the lowest index on a tie, class stop when all are zero
        for (int i = 0; i < NCLS; i++) begin
            if (votes[i] > best) begin
                best = votes[i];
                lead = i;
            end
        end
        if (best >= thresh_q) begin
            confirmed[lead] = 1'b1;
        end
        for (int i = 0; i < NCLS; i++) begin
            if (confirmed[i] && votes[i] <= release_q) begin
                r.cls  = REACT_W'(i);
                r.last = 1'b0;
                pending_reactions.push_back(r);
                confirmed[i] = 1'b0;
                fired++;
            end
        end
        // mark the final reaction of this detection's run
        if (fired != 0) begin
            pending_reactions[pending_reactions.size() - 1].last = 1'b1;
        end
    endfunction

    task automatic flag_mismatch(input string msg);
        $display("[%0t] MISMATCH: %s", $time, msg);
        mismatches++;
    endtask

    // ------------------------------------------------------------------------
    // Detection driver: offer the next queued code, hold it while full is up
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            push <= 1'b0;
        end else if (!push || !full) begin
            // previous request taken (or none offered): advance or idle
            if (detections.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
                push         <= 1'b1;
                i_class_code <= detections.pop_front();
            end else begin
                push <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Reaction receiver: random pop, plus one long hold-off on request,
    // counted here so the sender keeps pushing until full rises
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else if (hold_req && !hold_taken) begin
            hold_taken <= 1'b1;
            hold_left  <= LONG_HOLD_CYCLES;
            pop        <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            pop       <= 1'b0;
        end else begin
            pop <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: track register writes, predict on each taken detection and
    // compare each popped reaction with the oldest one owed
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : monitor
        t_reaction want;
        if (!i_rst_n) begin
            for (int i = 0; i < NCLS; i++) begin
                votes[i]     = '0;
                confirmed[i] = 1'b0;
            end
            limit_q   = COUNT_LIMIT_RST;
            thresh_q  = CONFIRM_THR_RST;
            release_q = RELEASE_LVL_RST;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_COUNT_LIMIT: limit_q   = i_cfg_data;
                    CFG_CONFIRM_THR: thresh_q  = i_cfg_data;
                    CFG_RELEASE_LVL: release_q = i_cfg_data;
                    default: ;  // spare index: drop the write
                endcase
            end
            // check before predicting: a reaction never leaves in the cycle
            // its detection is taken
            if (pop && !empty) begin
                if (pending_reactions.size() == 0) begin
                    flag_mismatch($sformatf("reaction class %0d last %0b with none owed",
                                            o_react_class, o_last_of_run));
                end else begin
                    want = pending_reactions.pop_front();
                    if (o_react_class !== want.cls) begin
                        flag_mismatch($sformatf("react_class got %0d want %0d",
                                                o_react_class, want.cls));
                    end
                    if (o_last_of_run !== want.last) begin
                        flag_mismatch($sformatf("last_of_run got %0b want %0b (class %0d)",
                                                o_last_of_run, want.last, want.cls));
                    end
                end
            end
            if (push && !full) begin
                tally_detection(i_class_code);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: end the run after too many cycles with no request taken
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n || (push && !full) || (pop && !empty) || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
            $display("[%0t] watchdog expired, block stopped moving", $time);
            $display("CHECKS FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic offer_run(input logic [CODE_W-1:0] code, input int unsigned len);
        repeat (len) detections.push_back(code);
    endtask

    // wait until every detection is taken and every reaction popped, then run on
    // for SETTLE_CYCLES so the front end is through with detections that release nothing
    task automatic drain();
        while (detections.size() != 0 || push || pending_reactions.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // mostly steady runs of one class (votes build, confirm, then fade),
    // the rest single noise codes over the whole field
    task automatic queue_sign_runs(input int unsigned n);
        int unsigned added;
        int unsigned len;
        logic [CODE_W-1:0] code;
        added = 0;
        while (added < n) begin
            if ($urandom_range(99) < 15) begin
                detections.push_back(CODE_W'($urandom_range(7)));
                added++;
            end else begin
                code = CODE_W'($urandom_range(CODE_NONE));
                len  = $urandom_range(1, 8);
                if (len > n - added) len = n - added;
                offer_run(code, len);
                added += len;
            end
        end
    endtask

    // small limits so that confirm and release happen often within a phase
    task automatic random_phase(input int unsigned tx_pct, input int unsigned rx_pct);
        int unsigned lim;
        int unsigned thr;
        tx_idle_pct <= tx_pct;
        rx_idle_pct <= rx_pct;
        lim = $urandom_range(1, 12);
        thr = $urandom_range(0, lim);
        write_reg(CFG_COUNT_LIMIT, CFG_W'(lim));
        write_reg(CFG_CONFIRM_THR, CFG_W'(thr));
        write_reg(CFG_RELEASE_LVL, CFG_W'($urandom_range(0, thr)));
        queue_sign_runs(ITEMS_PER_PHASE);
        drain();
    endtask

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    initial begin : stimulus
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed part, sender idling 37 in 100 and receiver 81 in 100

        // reset settings, all counters at zero: nothing confirms
        offer_run(CODE_NONE, 1);
        drain();

        // zero threshold with every counter at zero: stop confirms and
        // releases at once, also for an unknown code
        write_reg(CFG_CONFIRM_THR, 8'd0);
        write_reg(CFG_RELEASE_LVL, 8'd0);
        offer_run(CODE_NONE, 1);
        offer_run(3'd7, 1);
        drain();

        // zero limit holds a rising counter at zero
        write_reg(CFG_COUNT_LIMIT, 8'd0);
        write_reg(CFG_CONFIRM_THR, 8'hFF);
        write_reg(CFG_RELEASE_LVL, 8'hFF);
        offer_run(CODE_S30, 1);
        offer_run(CODE_S50, 1);
        drain();

        // confirm stop, then speed30 once it leads, with release held at zero
        write_reg(CFG_COUNT_LIMIT, 8'hFF);
        write_reg(CFG_CONFIRM_THR, 8'd0);
        write_reg(CFG_RELEASE_LVL, 8'd0);
        offer_run(CODE_STOP, 4);
        offer_run(CODE_S30, 3);
        drain();

        // open the release level: both confirmed classes go out in one run
        write_reg(CFG_RELEASE_LVL, 8'hFF);
        offer_run(CODE_S50, 1);
        drain();

        // build speedbump up, then a spare index write that must be dropped
        // and a limit below its counter, which clips it on the next vote
        write_reg(CFG_CONFIRM_THR, 8'd3);
        write_reg(CFG_RELEASE_LVL, 8'd1);
        offer_run(CODE_BUMP, 4);
        drain();
        write_reg(CFG_IDX_SPARE, 8'd0);
        write_reg(CFG_COUNT_LIMIT, 8'd2);
        offer_run(CODE_BUMP, 1);
        offer_run(3'd5, 1);
        offer_run(3'd6, 1);
        drain();

        // random part: idle pattern swaps, then no idling at all
        random_phase(37, 81);
        random_phase(81, 37);
        random_phase(0, 0);

        // every detection releases one class at once; hold the receiver off
        // for a long stretch so the block fills and raises full
        write_reg(CFG_COUNT_LIMIT, 8'd1);
        write_reg(CFG_CONFIRM_THR, 8'd0);
        write_reg(CFG_RELEASE_LVL, 8'hFF);
        hold_req <= 1'b1;
        queue_sign_runs(PRESSURE_ITEMS);
        drain();

        if (mismatches == 0 && pending_reactions.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
